/* rtl/core/isc_pkg.sv */
// Package for the itemset support counter.
// Request and register codes, default sizes and the token that runs down the cell chain.
// No dependencies.
package isc_pkg;

    localparam int DEF_MAX_PATTERNS = 64;
    localparam int DEF_MAX_WORDS    = 4;
    localparam int DEF_COUNT_BITS   = 32;

    localparam int REQ_W     = 2;
    localparam int PIDX_W    = 6;
    localparam int WIDX_W    = 2;
    localparam int DATA_W    = 64;
    localparam int SUPPORT_W = 32;
    localparam int CFG_W     = 7;
    localparam int PUSE_W    = 7;
    localparam int WPT_W     = 3;
    localparam int ID_W      = 11;
    localparam int NW_W      = 8;

    localparam logic [REQ_W-1:0] REQ_WRITE_PATTERN = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRANS_WORD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ_SUPPORT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL     = 2'd3;

    localparam logic CFG_PATTERNS_IN_USE = 1'b0;
    localparam logic CFG_WORDS_PER_TRANS = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic [REQ_W-1:0]     req;
        logic [PIDX_W-1:0]    pidx;
        logic [WIDX_W-1:0]    widx;
        logic [DATA_W-1:0]    data;
        logic                 word_ok;
        logic                 last;
        logic [ID_W-1:0]      npat;
        logic [SUPPORT_W-1:0] count;
    } t_token;

endpackage

/* rtl/core/itemset_support_counter.sv */
// Itemset support counter: top level with the entry stage and the chain of pattern cells.
// Depends on isc_pkg, isc_entry and isc_cell.
//
//  channel   ports                                                        direction
//  request   start, i_req_type, i_pattern_index, i_word_index,            in
//            i_data_word; busy                                            busy out
//  result    o_strobe, o_echo_index, o_support_count                      out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                              in
//
// A request is taken in every cycle; it walks the chain one cell per cycle.
// A support read returns through the chain register of every cell, in request order.
// busy stays low: the chain register of each cell is the only stage an item occupies.
// Reset sets default config, clears counters, miss flags and chain valids; pattern words stay.
// The receiver cannot stall; each result is shown for one cycle.
module itemset_support_counter import isc_pkg::*; #(
    parameter int MAX_PATTERNS = DEF_MAX_PATTERNS,
    parameter int MAX_WORDS    = DEF_MAX_WORDS,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [PIDX_W-1:0]    i_pattern_index,
    input  logic [WIDX_W-1:0]    i_word_index,
    input  logic [DATA_W-1:0]    i_data_word,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [PIDX_W-1:0]    o_echo_index,
    output logic [SUPPORT_W-1:0] o_support_count
);

    t_token chain [MAX_PATTERNS+1];
    t_token tail;

    assign busy = 1'b0;

    isc_entry #(
        .MAX_PATTERNS (MAX_PATTERNS),
        .MAX_WORDS    (MAX_WORDS)
    ) u_entry (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_take          (start && !busy),
        .i_req_type      (i_req_type),
        .i_pattern_index (i_pattern_index),
        .i_word_index    (i_word_index),
        .i_data_word     (i_data_word),
        .o_tok           (chain[0])
    );

    for (genvar g = 0; g < MAX_PATTERNS; g++) begin : g_cell
        isc_cell #(
            .CELL_ID    (g),
            .MAX_WORDS  (MAX_WORDS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (chain[g]),
            .o_tok   (chain[g+1])
        );
    end

    assign tail            = chain[MAX_PATTERNS];
    assign o_strobe        = tail.valid && (tail.req == REQ_READ_SUPPORT);
    assign o_echo_index    = tail.pidx;
    assign o_support_count = tail.count;

    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_req_type, MAX_PATTERNS) == REQ_READ_SUPPORT)
        else $error("result strobe without a matching support read");

    a_echo_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_echo_index == $past(i_pattern_index, MAX_PATTERNS))
        else $error("echo index does not follow the read request");

    a_out_of_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (ID_W'(o_echo_index) >= ID_W'(MAX_PATTERNS))) |-> o_support_count == '0)
        else $error("read beyond the pattern store returned a non-zero count");

endmodule

/* rtl/core/isc_entry.sv */
// Configuration registers and request decode at the head of the cell chain.
// Depends on isc_pkg.
module isc_entry import isc_pkg::*; #(
    parameter int MAX_PATTERNS = DEF_MAX_PATTERNS,
    parameter int MAX_WORDS    = DEF_MAX_WORDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_take,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [PIDX_W-1:0] i_pattern_index,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [DATA_W-1:0] i_data_word,
    output t_token            o_tok
);

    logic [PUSE_W-1:0] r_pat_use;
    logic [WPT_W-1:0]  r_words;
    logic [NW_W-1:0]   nw;
    logic [NW_W-1:0]   widx_ext;
    logic [ID_W-1:0]   puse_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_use <= PUSE_W'(64);
            r_words   <= WPT_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERNS_IN_USE: r_pat_use <= i_cfg_data[PUSE_W-1:0];
                CFG_WORDS_PER_TRANS: r_words   <= i_cfg_data[WPT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_words == '0) begin
            nw = NW_W'(1);
        end else if (NW_W'(r_words) > NW_W'(MAX_WORDS)) begin
            nw = NW_W'(MAX_WORDS);
        end else begin
            nw = NW_W'(r_words);
        end
        widx_ext = NW_W'(i_word_index);
        puse_ext = ID_W'(r_pat_use);

        o_tok.valid   = i_take;
        o_tok.req     = i_req_type;
        o_tok.pidx    = i_pattern_index;
        o_tok.widx    = i_word_index;
        o_tok.data    = i_data_word;
        o_tok.word_ok = widx_ext < nw;
        o_tok.last    = widx_ext == (nw - NW_W'(1));
        o_tok.npat    = (puse_ext > ID_W'(MAX_PATTERNS)) ? ID_W'(MAX_PATTERNS) : puse_ext;
        o_tok.count   = '0;
    end

endmodule

/* rtl/core/isc_cell.sv */
// One pattern cell: pattern words, miss flag and support counter.
// Acts on the passing token and hands it on to the next cell. Depends on isc_pkg.
module isc_cell import isc_pkg::*; #(
    parameter int CELL_ID    = 0,
    parameter int MAX_WORDS  = DEF_MAX_WORDS,
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok
);

    localparam int WSEL_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [DATA_W-1:0]     r_pat [MAX_WORDS];
    logic                  r_miss;
    logic [COUNT_BITS-1:0] r_count;
    t_token                r_tok;
    t_token                n_tok;

    logic [NW_W-1:0]       widx_ext;
    logic [WSEL_W-1:0]     wsel;
    logic                  hit;
    logic                  in_use;
    logic                  wr_ok;
    logic                  miss_now;
    logic                  is_trans;
    logic [63:0]           cnt_ext;

    always_comb begin
        widx_ext = NW_W'(i_tok.widx);
        wsel     = widx_ext[WSEL_W-1:0];
        hit      = ID_W'(i_tok.pidx) == ID_W'(CELL_ID);
        in_use   = ID_W'(CELL_ID) < i_tok.npat;
        wr_ok    = widx_ext < NW_W'(MAX_WORDS);
        is_trans = i_tok.valid && (i_tok.req == REQ_TRANS_WORD) && i_tok.word_ok;
        miss_now = r_miss | (|(r_pat[wsel] & ~i_tok.data));
        cnt_ext  = 64'(r_count);
        n_tok    = i_tok;
        if (i_tok.valid && (i_tok.req == REQ_READ_SUPPORT) && hit) begin
            n_tok.count = cnt_ext[SUPPORT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.valid && (i_tok.req == REQ_WRITE_PATTERN) && hit && wr_ok) begin
            r_pat[wsel] <= i_tok.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss  <= 1'b0;
            r_count <= '0;
        end else begin
            if (is_trans) begin
                if (i_tok.last) begin
                    r_miss <= 1'b0;
                    if (in_use && !miss_now && (r_count != '1)) begin
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                end else if (in_use) begin
                    r_miss <= miss_now;
                end
            end
            if (i_tok.valid && (i_tok.req == REQ_CLEAR_ALL)) begin
                r_count <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
